// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the request engine modules.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define UDRE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define UDRE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/udre_pkg.sv -----
// Types and constants of the DFU request engine.
// No dependencies; used by every module of the block.
package udre_pkg;

    localparam int XFER_LEN_W = 12;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [3:0] {
        ST_IDLE          = 4'd2,
        ST_DNLOAD_SYNC   = 4'd3,
        ST_DNBUSY        = 4'd4,
        ST_DNLOAD_IDLE   = 4'd5,
        ST_MANIFEST_SYNC = 4'd6,
        ST_MANIFEST      = 4'd7,
        ST_UPLOAD_IDLE   = 4'd9,
        ST_ERROR         = 4'd10
    } dfu_state_t;

    typedef enum logic [3:0] {
        OP_DNLOAD      = 4'd0,
        OP_UPLOAD      = 4'd1,
        OP_GETSTATUS   = 4'd2,
        OP_CLRSTATUS   = 4'd3,
        OP_GETSTATE    = 4'd4,
        OP_ABORT       = 4'd5,
        OP_DETACH      = 4'd6,
        OP_STATUS_DONE = 4'd7,
        OP_OTHER       = 4'd8
    } op_t;

    localparam logic [2:0] RK_NONE    = 3'd0;
    localparam logic [2:0] RK_STATUS  = 3'd1;
    localparam logic [2:0] RK_STATE   = 3'd2;
    localparam logic [2:0] RK_CMDLIST = 3'd3;
    localparam logic [2:0] RK_DATA    = 3'd4;
    localparam logic [2:0] RK_EMPTY   = 3'd5;

    localparam logic [1:0] FA_NONE    = 2'd0;
    localparam logic [1:0] FA_ERASE   = 2'd1;
    localparam logic [1:0] FA_PROGRAM = 2'd2;
    localparam logic [1:0] FA_READ    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPLOAD_EN = 2'd2;

    localparam logic [7:0]  PCMD_SETADDR   = 8'h21;
    localparam logic [7:0]  PCMD_ERASE     = 8'h41;
    localparam logic [23:0] BUSY_POLL_MS   = 24'd100;
    localparam logic [7:0]  STATUS_ERROR   = 8'd10;
    localparam logic [10:0] LEN_STATUS     = 11'd6;
    localparam logic [10:0] LEN_STATE      = 11'd1;
    localparam logic [10:0] LEN_CMDLIST    = 11'd3;
    localparam logic [16:0] FIRST_DATA_BLK = 17'd2;

    localparam logic [31:0] WIN_START_RST = 32'h0800_0000;
    localparam logic [31:0] WIN_END_RST   = 32'h0801_0000;

    typedef struct packed {
        op_t                   op;
        logic                  blk_zero;
        logic                  len_zero;
        logic [XFER_LEN_W-1:0] len;
        logic [7:0]            pcmd;
        logic [31:0]           paddr;
        logic [31:0]           blk_off;
    } req_item_t;

    typedef struct packed {
        logic        handled;
        logic [2:0]  reply_kind;
        logic [10:0] reply_len;
        logic [7:0]  status_code;
        logic [23:0] poll_timeout;
        dfu_state_t  state_out;
        logic [1:0]  flash_action;
        logic [31:0] flash_addr;
        logic [10:0] flash_len;
    } result_t;

endpackage

// ----- hdl/usb_dfu_request_engine.sv -----
// USB DFU class request engine with address/erase extension, top level.
// Sustains one item per clock while results are taken. A result passes the
// front decode register, two-entry queue and result register; the input
// keeps accepting while a result waits until queue and front register fill.
// The rate is set by the back stage, which updates the DFU state and runs
// one window check per cycle. Configuration writes are taken every cycle.
// Depends on udre_pkg, udre_front, udre_fifo and udre_back.
module usb_dfu_request_engine #(
    parameter int TRANSFER_SIZE = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [udre_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [3:0]                     s_cmd,
    input  logic [15:0]                    s_block_num,
    input  logic [15:0]                    s_req_length,
    input  logic [7:0]                     s_payload_cmd,
    input  logic [31:0]                    s_payload_addr,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_handled,
    output logic [2:0]                     m_reply_kind,
    output logic [10:0]                    m_reply_len,
    output logic [7:0]                     m_status_code,
    output logic [23:0]                    m_poll_timeout,
    output logic [3:0]                     m_state_out,
    output logic [1:0]                     m_flash_action,
    output logic [31:0]                    m_flash_addr,
    output logic [10:0]                    m_flash_len
);
    import udre_pkg::*;

    logic      push;
    logic      q_full;
    logic      q_not_empty;
    logic      pop;
    req_item_t push_item;
    req_item_t head;
    result_t   res;

    udre_front #(
        .TRANSFER_SIZE (TRANSFER_SIZE)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_block_num    (s_block_num),
        .s_req_length   (s_req_length),
        .s_payload_cmd  (s_payload_cmd),
        .s_payload_addr (s_payload_addr),
        .push           (push),
        .q_full         (q_full),
        .push_item      (push_item)
    );

    udre_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head)
    );

    udre_back #(
        .TRANSFER_SIZE (TRANSFER_SIZE)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head_valid (q_not_empty),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (res)
    );

    assign m_handled      = res.handled;
    assign m_reply_kind   = res.reply_kind;
    assign m_reply_len    = res.reply_len;
    assign m_status_code  = res.status_code;
    assign m_poll_timeout = res.poll_timeout;
    assign m_state_out    = res.state_out;
    assign m_flash_action = res.flash_action;
    assign m_flash_addr   = res.flash_addr;
    assign m_flash_len    = res.flash_len;

endmodule

// ----- hdl/udre_front.sv -----
// Front stage: accepts request items, decodes the command, clamps the length
// and computes the block offset. Depends on udre_pkg.
module udre_front #(
    parameter int TRANSFER_SIZE = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [3:0]           s_cmd,
    input  logic [15:0]          s_block_num,
    input  logic [15:0]          s_req_length,
    input  logic [7:0]           s_payload_cmd,
    input  logic [31:0]          s_payload_addr,
    output logic                 push,
    input  logic                 q_full,
    output udre_pkg::req_item_t  push_item
);
    import udre_pkg::*;

    localparam int PROD_W = 17 + XFER_LEN_W + 1;
    localparam logic signed [XFER_LEN_W:0] TS_VEC = (XFER_LEN_W + 1)'(TRANSFER_SIZE);

    logic      valid_reg;
    req_item_t item_reg;
    req_item_t item_next;

    logic signed [16:0]       blk_diff;
    logic signed [PROD_W-1:0] blk_prod;

    always_comb begin
        blk_diff = $signed({1'b0, s_block_num}) - $signed(FIRST_DATA_BLK);
        blk_prod = PROD_W'(blk_diff) * PROD_W'(TS_VEC);
        item_next.op       = (s_cmd > 4'(OP_STATUS_DONE)) ? OP_OTHER : op_t'(s_cmd);
        item_next.blk_zero = (s_block_num == 16'd0);
        item_next.len_zero = (s_req_length == 16'd0);
        item_next.len      = (s_req_length > 16'(TRANSFER_SIZE)) ?
                             XFER_LEN_W'(TRANSFER_SIZE) : s_req_length[XFER_LEN_W-1:0];
        item_next.pcmd     = s_payload_cmd;
        item_next.paddr    = s_payload_addr;
        item_next.blk_off  = {{(32 - PROD_W){blk_prod[PROD_W-1]}}, blk_prod};
    end

    assign push      = valid_reg && !q_full;
    assign s_ready   = !valid_reg || !q_full;
    assign push_item = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (push) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- hdl/udre_fifo.sv -----
// Two-entry queue of decoded request items between front and back.
// Depends on udre_pkg and assert_macros.svh.
`include "assert_macros.svh"

module udre_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  udre_pkg::req_item_t push_item,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output udre_pkg::req_item_t head
);
    import udre_pkg::*;

    req_item_t  mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    `UDRE_ASSERT(a_no_overflow, aclk, aresetn, push |-> !full, "push into full queue")
    `UDRE_ASSERT(a_no_underflow, aclk, aresetn, pop |-> not_empty, "pop from empty queue")
    `UDRE_ASSERT(a_count_range, aclk, aresetn, count_reg != 2'd3, "queue count out of range")

endmodule

// ----- hdl/udre_back.sv -----
// Back stage: DFU state, saved download block, window check, config
// registers and the result register. Depends on udre_pkg and assert_macros.svh.
`include "assert_macros.svh"

module udre_back #(
    parameter int TRANSFER_SIZE = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [udre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            head_valid,
    input  udre_pkg::req_item_t             head,
    output logic                            pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output udre_pkg::result_t               m_res
);
    import udre_pkg::*;

    localparam logic [XFER_LEN_W-1:0] TS_LEN = XFER_LEN_W'(TRANSFER_SIZE);
    localparam logic [10:0]           TS_OUT = 11'(TRANSFER_SIZE);

    logic [31:0] win_start_reg;
    logic [31:0] win_end_reg;
    logic        upload_en_reg;

    dfu_state_t            dfu_state_reg, dfu_state_next;
    logic [31:0]           addr_ptr_reg, addr_ptr_next;
    logic                  saved_blk_zero_reg, saved_blk_zero_next;
    logic [31:0]           saved_off_reg, saved_off_next;
    logic [XFER_LEN_W-1:0] saved_len_reg, saved_len_next;
    logic [7:0]            saved_cmd_reg, saved_cmd_next;
    logic [31:0]           saved_cmd_addr_reg, saved_cmd_addr_next;

    logic    m_valid_reg;
    result_t res_reg, res_next;

    logic [31:0]           blk_addr;
    logic [31:0]           chk_base;
    logic [XFER_LEN_W-1:0] chk_len;
    logic [31:0]           chk_top;
    logic                  win_ok;

    assign cfg_ready = 1'b1;
    assign pop       = head_valid && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_res     = res_reg;

    // shared window check: upload block, erase page or program block
    always_comb begin
        blk_addr = addr_ptr_reg + ((head.op == OP_UPLOAD) ? head.blk_off : saved_off_reg);
        chk_base = (head.op == OP_STATUS_DONE && saved_blk_zero_reg) ?
                   saved_cmd_addr_reg : blk_addr;
        chk_len  = (head.op == OP_UPLOAD || saved_blk_zero_reg) ? TS_LEN : saved_len_reg;
        chk_top  = chk_base + 32'(chk_len);
        win_ok   = (chk_base >= win_start_reg) && (chk_top <= win_end_reg);
    end

    always_comb begin
        dfu_state_next      = dfu_state_reg;
        addr_ptr_next       = addr_ptr_reg;
        saved_blk_zero_next = saved_blk_zero_reg;
        saved_off_next      = saved_off_reg;
        saved_len_next      = saved_len_reg;
        saved_cmd_next      = saved_cmd_reg;
        saved_cmd_addr_next = saved_cmd_addr_reg;
        if (pop) begin
            unique case (head.op)
                OP_DNLOAD: begin
                    if (head.len_zero) begin
                        dfu_state_next = ST_MANIFEST_SYNC;
                    end else begin
                        saved_blk_zero_next = head.blk_zero;
                        saved_off_next      = head.blk_off;
                        saved_len_next      = head.len;
                        saved_cmd_next      = head.pcmd;
                        saved_cmd_addr_next = head.paddr;
                        dfu_state_next      = ST_DNLOAD_SYNC;
                    end
                end
                OP_UPLOAD: begin
                    if (head.blk_zero || (upload_en_reg && win_ok)) begin
                        dfu_state_next = ST_UPLOAD_IDLE;
                    end else begin
                        dfu_state_next = ST_ERROR;
                    end
                end
                OP_GETSTATUS: begin
                    if (dfu_state_reg == ST_DNLOAD_SYNC) begin
                        dfu_state_next = ST_DNBUSY;
                    end else if (dfu_state_reg == ST_MANIFEST_SYNC) begin
                        dfu_state_next = ST_MANIFEST;
                    end
                end
                OP_CLRSTATUS: begin
                    if (dfu_state_reg == ST_ERROR) begin
                        dfu_state_next = ST_IDLE;
                    end
                end
                OP_ABORT:  dfu_state_next = ST_IDLE;
                OP_DETACH: dfu_state_next = ST_MANIFEST;
                OP_STATUS_DONE: begin
                    if (dfu_state_reg == ST_DNBUSY) begin
                        if (saved_blk_zero_reg && saved_cmd_reg == PCMD_SETADDR) begin
                            addr_ptr_next = saved_cmd_addr_reg;
                        end
                        dfu_state_next = ST_DNLOAD_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        res_next              = '0;
        res_next.handled      = 1'b1;
        res_next.reply_kind   = RK_NONE;
        res_next.flash_action = FA_NONE;
        res_next.state_out    = dfu_state_next;
        unique case (head.op)
            OP_DNLOAD: res_next.reply_kind = RK_EMPTY;
            OP_UPLOAD: begin
                if (head.blk_zero) begin
                    res_next.reply_kind = RK_CMDLIST;
                    res_next.reply_len  = LEN_CMDLIST;
                end else if (upload_en_reg && win_ok) begin
                    res_next.reply_kind   = RK_DATA;
                    res_next.reply_len    = TS_OUT;
                    res_next.flash_action = FA_READ;
                    res_next.flash_addr   = blk_addr;
                    res_next.flash_len    = TS_OUT;
                end else begin
                    res_next.reply_kind = RK_EMPTY;
                end
            end
            OP_GETSTATUS: begin
                res_next.reply_kind = RK_STATUS;
                res_next.reply_len  = LEN_STATUS;
                if (dfu_state_reg == ST_DNLOAD_SYNC) begin
                    res_next.poll_timeout = BUSY_POLL_MS;
                end else if (dfu_state_reg == ST_ERROR) begin
                    res_next.status_code = STATUS_ERROR;
                end
            end
            OP_CLRSTATUS, OP_ABORT, OP_DETACH: res_next.reply_kind = RK_EMPTY;
            OP_GETSTATE: begin
                res_next.reply_kind = RK_STATE;
                res_next.reply_len  = LEN_STATE;
            end
            OP_STATUS_DONE: begin
                if (dfu_state_reg == ST_DNBUSY && win_ok) begin
                    if (saved_blk_zero_reg) begin
                        if (saved_cmd_reg == PCMD_ERASE) begin
                            res_next.flash_action = FA_ERASE;
                            res_next.flash_addr   = saved_cmd_addr_reg;
                        end
                    end else begin
                        res_next.flash_action = FA_PROGRAM;
                        res_next.flash_addr   = blk_addr;
                        res_next.flash_len    = saved_len_reg[10:0];
                    end
                end
            end
            default: res_next.handled = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_start_reg <= WIN_START_RST;
            win_end_reg   <= WIN_END_RST;
            upload_en_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_WIN_START: win_start_reg <= cfg_data;
                CFG_WIN_END:   win_end_reg   <= cfg_data;
                CFG_UPLOAD_EN: upload_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dfu_state_reg      <= ST_IDLE;
            addr_ptr_reg       <= '0;
            saved_blk_zero_reg <= 1'b1;
            saved_off_reg      <= '0;
            saved_len_reg      <= '0;
            saved_cmd_reg      <= '0;
            saved_cmd_addr_reg <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            dfu_state_reg      <= dfu_state_next;
            addr_ptr_reg       <= addr_ptr_next;
            saved_blk_zero_reg <= saved_blk_zero_next;
            saved_off_reg      <= saved_off_next;
            saved_len_reg      <= saved_len_next;
            saved_cmd_reg      <= saved_cmd_next;
            saved_cmd_addr_reg <= saved_cmd_addr_next;
            if (pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= res_next;
        end
    end

    `UDRE_ASSERT(a_err_status, aclk, aresetn, (m_valid_reg && res_reg.status_code != 8'd0) |-> (res_reg.state_out == ST_ERROR), "error status outside error state")
    `UDRE_ASSERT(a_prog_state, aclk, aresetn, (m_valid_reg && res_reg.flash_action == FA_PROGRAM) |-> (res_reg.state_out == ST_DNLOAD_IDLE), "program issued outside download idle")
    `UDRE_ASSERT(a_busy_exit, aclk, aresetn, (pop && head.op == OP_STATUS_DONE && dfu_state_reg == ST_DNBUSY) |=> (dfu_state_reg == ST_DNLOAD_IDLE), "busy state not left on status complete")

endmodule
